[rtl/core/tss_pkg.sv]
// Shared constants for the scanline span unit.
// No dependencies; imported by the span pipeline and its vertex sorter.
package tss_pkg;

    localparam int COLOR_BITS  = 32;
    localparam int NUM_VERTS   = 3;

endpackage

[rtl/core/tss_sort.sv]
// Three-stage compare-and-swap network that orders triangle vertices by y.
// Combinational; depends on tss_pkg for the vertex count.
module tss_sort #(
    parameter int COORD_BITS = 10
) (
    input  logic [tss_pkg::NUM_VERTS*COORD_BITS-1:0] i_x,
    input  logic [tss_pkg::NUM_VERTS*COORD_BITS-1:0] i_y,
    output logic [tss_pkg::NUM_VERTS*COORD_BITS-1:0] o_x,
    output logic [tss_pkg::NUM_VERTS*COORD_BITS-1:0] o_y
);
    import tss_pkg::*;

    logic [COORD_BITS-1:0] ax, ay, bx, by, cx, cy;
    logic [COORD_BITS-1:0] ax1, ay1, bx1, by1;
    logic [COORD_BITS-1:0] ax2, ay2, cx2, cy2;
    logic [COORD_BITS-1:0] bx3, by3, cx3, cy3;

    assign ax = i_x[COORD_BITS-1:0];
    assign bx = i_x[2*COORD_BITS-1:COORD_BITS];
    assign cx = i_x[3*COORD_BITS-1:2*COORD_BITS];
    assign ay = i_y[COORD_BITS-1:0];
    assign by = i_y[2*COORD_BITS-1:COORD_BITS];
    assign cy = i_y[3*COORD_BITS-1:2*COORD_BITS];

    // Swaps happen only on strictly greater y; vertices with equal y may still be reordered.
    always_comb begin
        if (ay > by) begin
            ax1 = bx; ay1 = by; bx1 = ax; by1 = ay;
        end else begin
            ax1 = ax; ay1 = ay; bx1 = bx; by1 = by;
        end
        if (ay1 > cy) begin
            ax2 = cx; ay2 = cy; cx2 = ax1; cy2 = ay1;
        end else begin
            ax2 = ax1; ay2 = ay1; cx2 = cx; cy2 = cy;
        end
        if (by1 > cy2) begin
            bx3 = cx2; by3 = cy2; cx3 = bx1; cy3 = by1;
        end else begin
            bx3 = bx1; by3 = by1; cx3 = cx2; cy3 = cy2;
        end
    end

    assign o_x = {cx3, bx3, ax2};
    assign o_y = {cy3, by3, ay2};

endmodule

[rtl/core/triangle_scanline_span.sv]
// Scanline span unit: sorts a triangle's vertices and returns the span on one row.
// Depends on tss_pkg and tss_sort.
//
// Usage: each transaction on the s_axis side carries three vertices, a row and a
// color. Exactly one transaction leaves on the m_axis side for each one accepted,
// in order: the half-open span [start, end) of the triangle on that row, the row,
// the color, and in tuser a coverage flag (0 for rows outside the triangle or for
// a zero-height triangle, with start and end then 0).
// The pipeline has COORD_BITS + 3 register stages: one sort stage, one setup stage
// holding the edge multipliers, one restoring-division stage per quotient bit
// (both edges in parallel), and the output register.
// Throughput is one transaction per cycle while m_axis_tready is high. Each stage
// has its own valid bit and loads whenever it is empty or its successor moves, so
// bubbles close up and the input keeps taking transactions while a result waits in
// the output register, until every stage is full.
// When the receiver holds m_axis_tready low, the output result is kept unchanged
// and nothing is dropped or repeated. Reset (synchronous, active low) empties all
// stages; payload registers are not reset.
module triangle_scanline_span #(
    parameter int COORD_BITS = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // Fields from bit 0: vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x,
    // vert_c_y, row, fill_color, zero padding.
    input  logic [((7*COORD_BITS+tss_pkg::COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // Fields from bit 0: span_start, span_end, span_row, span_color, zero padding.
    output logic [((3*COORD_BITS+tss_pkg::COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
    // Field: row_covered.
    output logic m_axis_tuser
);
    import tss_pkg::*;

    localparam int CB      = COORD_BITS;
    localparam int NDIV    = COORD_BITS;
    localparam int NSTG    = NDIV + 3;
    localparam int OUT_W   = ((3*COORD_BITS+COLOR_BITS+7)/8)*8;
    localparam int OUT_PAD = OUT_W - (3*COORD_BITS+COLOR_BITS);

    typedef struct packed {
        logic [CB-1:0]         ax;
        logic [CB-1:0]         ay;
        logic [CB-1:0]         bx;
        logic [CB-1:0]         by;
        logic [CB-1:0]         cx;
        logic [CB-1:0]         cy;
        logic [CB-1:0]         row;
        logic [COLOR_BITS-1:0] color;
    } t_sorted;

    // Long edge (l) and short edge (s) divisions travel side by side.
    typedef struct packed {
        logic [CB-1:0]         row;
        logic [COLOR_BITS-1:0] color;
        logic                  covered;
        logic [CB-1:0]         x0l;
        logic [CB-1:0]         x0s;
        logic                  negl;
        logic                  negs;
        logic [CB-1:0]         dl;
        logic [CB-1:0]         ds;
        logic [CB-1:0]         rl;
        logic [CB-1:0]         rs;
        logic [CB-1:0]         nl;
        logic [CB-1:0]         ns;
        logic [CB-1:0]         ql;
        logic [CB-1:0]         qs;
    } t_div;

    typedef struct packed {
        logic [CB-1:0]         start;
        logic [CB-1:0]         stop;
        logic                  covered;
        logic [CB-1:0]         row;
        logic [COLOR_BITS-1:0] color;
    } t_out;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG:0]   en;

    t_sorted r_sort;
    t_sorted n_sort;
    t_div    r_div [0:NDIV];
    t_div    n_div [0:NDIV];
    t_out    r_out;
    t_out    n_out;

    logic [3*CB-1:0] sort_x;
    logic [3*CB-1:0] sort_y;

    // Stall chain: a stage loads when it is empty or its successor advances.
    always_comb begin
        en[NSTG] = m_axis_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign n_vld         = {r_vld[NSTG-2:0], s_axis_tvalid};
    assign s_axis_tready = en[0];
    assign m_axis_tvalid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (en[NSTG-1:0] & n_vld) | (~en[NSTG-1:0] & r_vld);
        end
    end

    // Sort stage.
    tss_sort #(
        .COORD_BITS(COORD_BITS)
    ) u_sort (
        .i_x({s_axis_tdata[5*CB-1:4*CB], s_axis_tdata[3*CB-1:2*CB],
              s_axis_tdata[CB-1:0]}),
        .i_y({s_axis_tdata[6*CB-1:5*CB], s_axis_tdata[4*CB-1:3*CB],
              s_axis_tdata[2*CB-1:CB]}),
        .o_x(sort_x),
        .o_y(sort_y)
    );

    always_comb begin
        n_sort.ax    = sort_x[CB-1:0];
        n_sort.bx    = sort_x[2*CB-1:CB];
        n_sort.cx    = sort_x[3*CB-1:2*CB];
        n_sort.ay    = sort_y[CB-1:0];
        n_sort.by    = sort_y[2*CB-1:CB];
        n_sort.cy    = sort_y[3*CB-1:2*CB];
        n_sort.row   = s_axis_tdata[7*CB-1:6*CB];
        n_sort.color = s_axis_tdata[7*CB+COLOR_BITS-1:7*CB];
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_sort <= n_sort;
        end
    end

    // Setup stage: edge selection, deltas and numerator magnitudes.
    always_comb begin
        logic          upper;
        logic [CB:0]   dxl;
        logic [CB:0]   dxs;
        logic [CB:0]   negdl;
        logic [CB:0]   negds;
        logic [CB-1:0] magl;
        logic [CB-1:0] mags;
        logic [CB-1:0] yl;
        logic [CB-1:0] ys;
        logic [2*CB-1:0] prodl;
        logic [2*CB-1:0] prods;

        upper = (r_sort.ay != r_sort.by) && (r_sort.row <= r_sort.by);
        dxl   = {1'b0, r_sort.cx} - {1'b0, r_sort.ax};
        yl    = r_sort.row - r_sort.ay;
        if (upper) begin
            dxs          = {1'b0, r_sort.bx} - {1'b0, r_sort.ax};
            ys           = r_sort.row - r_sort.ay;
            n_div[0].ds  = r_sort.by - r_sort.ay;
            n_div[0].x0s = r_sort.ax;
        end else begin
            dxs          = {1'b0, r_sort.cx} - {1'b0, r_sort.bx};
            ys           = r_sort.row - r_sort.by;
            n_div[0].ds  = r_sort.cy - r_sort.by;
            n_div[0].x0s = r_sort.bx;
        end
        negdl = ~dxl + 1'b1;
        negds = ~dxs + 1'b1;
        magl  = dxl[CB] ? negdl[CB-1:0] : dxl[CB-1:0];
        mags  = dxs[CB] ? negds[CB-1:0] : dxs[CB-1:0];
        prodl = (2*CB)'(magl) * (2*CB)'(yl);
        prods = (2*CB)'(mags) * (2*CB)'(ys);

        n_div[0].row     = r_sort.row;
        n_div[0].color   = r_sort.color;
        n_div[0].covered = (r_sort.cy != r_sort.ay) && (r_sort.row >= r_sort.ay)
                           && (r_sort.row <= r_sort.cy);
        n_div[0].x0l     = r_sort.ax;
        n_div[0].negl    = dxl[CB];
        n_div[0].negs    = dxs[CB];
        n_div[0].dl      = r_sort.cy - r_sort.ay;
        // The quotient never exceeds the x delta, so the upper half of each
        // product is already below its divisor.
        n_div[0].rl      = prodl[2*CB-1:CB];
        n_div[0].rs      = prods[2*CB-1:CB];
        n_div[0].nl      = prodl[CB-1:0];
        n_div[0].ns      = prods[CB-1:0];
        n_div[0].ql      = '0;
        n_div[0].qs      = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_div[0] <= n_div[0];
        end
    end

    // Restoring division, one quotient bit per stage for each edge.
    for (genvar j = 1; j <= NDIV; j++) begin : g_div
        always_comb begin
            logic [CB:0] tl;
            logic [CB:0] ts;
            logic [CB:0] difl;
            logic [CB:0] difs;
            logic        bl;
            logic        bs;

            tl   = {r_div[j-1].rl, r_div[j-1].nl[CB-1]};
            ts   = {r_div[j-1].rs, r_div[j-1].ns[CB-1]};
            difl = tl - {1'b0, r_div[j-1].dl};
            difs = ts - {1'b0, r_div[j-1].ds};
            bl   = (tl >= {1'b0, r_div[j-1].dl});
            bs   = (ts >= {1'b0, r_div[j-1].ds});

            n_div[j]    = r_div[j-1];
            n_div[j].rl = bl ? difl[CB-1:0] : tl[CB-1:0];
            n_div[j].rs = bs ? difs[CB-1:0] : ts[CB-1:0];
            n_div[j].nl = {r_div[j-1].nl[CB-2:0], 1'b0};
            n_div[j].ns = {r_div[j-1].ns[CB-2:0], 1'b0};
            n_div[j].ql = {r_div[j-1].ql[CB-2:0], bl};
            n_div[j].qs = {r_div[j-1].qs[CB-2:0], bs};
        end

        always_ff @(posedge i_clk) begin
            if (en[j+1]) begin
                r_div[j] <= n_div[j];
            end
        end
    end

    // Output stage: apply sign (truncation toward zero), add base, order or zero the span.
    always_comb begin
        logic [CB+1:0] ql_ext;
        logic [CB+1:0] qs_ext;
        logic [CB+1:0] sum_l;
        logic [CB+1:0] sum_s;
        logic [CB-1:0] xl;
        logic [CB-1:0] xs;

        ql_ext = {2'b00, r_div[NDIV].ql};
        qs_ext = {2'b00, r_div[NDIV].qs};
        sum_l  = {2'b00, r_div[NDIV].x0l}
                 + (r_div[NDIV].negl ? (~ql_ext + 1'b1) : ql_ext);
        sum_s  = {2'b00, r_div[NDIV].x0s}
                 + (r_div[NDIV].negs ? (~qs_ext + 1'b1) : qs_ext);
        xl     = sum_l[CB-1:0];
        xs     = sum_s[CB-1:0];

        n_out.covered = r_div[NDIV].covered;
        n_out.row     = r_div[NDIV].row;
        n_out.color   = r_div[NDIV].color;
        if (!r_div[NDIV].covered) begin
            n_out.start = '0;
            n_out.stop  = '0;
        end else if (xl < xs) begin
            n_out.start = xl;
            n_out.stop  = xs;
        end else begin
            n_out.start = xs;
            n_out.stop  = xl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NSTG-1]) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tdata = {{OUT_PAD{1'b0}}, r_out.color, r_out.row, r_out.stop,
                           r_out.start};
    assign m_axis_tuser = r_out.covered;

endmodule
